### hw/rtl/lokf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the longest-ones-with-flips block.
// No dependencies; every other file refers to it by scoped names.
package lokf_pkg;

   localparam int MAX_FLIPS  = 64;
   localparam int MAX_LEN    = 65536;

   localparam int CFG_W      = 7;
   localparam int LEN_W      = 17;
   localparam int POS_W      = $clog2(MAX_LEN);
   localparam int CNT_W      = $clog2(MAX_FLIPS + 1);
   localparam int IDX_W      = (MAX_FLIPS > 1) ? $clog2(MAX_FLIPS) : 1;
   localparam int GROUP_SIZE = 8;
   localparam int GROUPS     = (MAX_FLIPS + GROUP_SIZE - 1) / GROUP_SIZE;

   // per-request info carried from the chain stage to the span stage
   typedef struct packed {
      logic [LEN_W-1:0] here;
      logic             drop;
      logic             zero_restart;
      logic             counted;
      logic             last;
      logic             overflow;
   } lokf_meta_type;

endpackage

### hw/rtl/lokf_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces (valid/ready plus payload).
// Depends on lokf_pkg for field widths.
interface lokf_req_if;
   logic valid;
   logic ready;
   logic bit_value;
   logic last;

   modport source (output valid, output bit_value, output last, input ready);
   modport sink   (input valid, input bit_value, input last, output ready);
endinterface

interface lokf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lokf_pkg::LEN_W-1:0]  best_length;
   logic                        done_res;
   logic                        overflow;

   modport source (output valid, output best_length, output done_res, output overflow,
                   input ready);
   modport sink   (input valid, input best_length, input done_res, input overflow,
                   output ready);
endinterface

### hw/rtl/lokf_cell.sv
`timescale 1ns / 1ps
// One cell of the zero-position chain: holds one zero position.
// Depends on lokf_pkg.
module lokf_cell (
   input  logic                       clock,
   input  logic                       shift_en,
   input  logic [lokf_pkg::POS_W-1:0] left_pos,
   input  logic                       sel,
   output logic [lokf_pkg::POS_W-1:0] pos,
   output logic [lokf_pkg::POS_W-1:0] pick
);

   logic [lokf_pkg::POS_W-1:0] pos_ff;
   logic [lokf_pkg::POS_W-1:0] pos_in;

   assign pos_in = shift_en ? left_pos : pos_ff;

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
   end

   assign pos  = pos_ff;
   assign pick = pos_ff & {lokf_pkg::POS_W{sel}};

endmodule

### hw/rtl/lokf_chain.sv
`timescale 1ns / 1ps
// Row of cells holding the most recent zero positions, newest in cell 0,
// with a registered OR tree that extracts the selected cell.
// Depends on lokf_pkg and lokf_cell.
module lokf_chain (
   input  logic                       clock,
   input  logic                       shift_en,
   input  logic [lokf_pkg::POS_W-1:0] new_pos,
   input  logic                       pick_en,
   input  logic [lokf_pkg::IDX_W-1:0] pick_index,
   input  logic                       load_en,
   output logic [lokf_pkg::POS_W-1:0] picked_pos
);

   logic [lokf_pkg::POS_W-1:0] cell_pos  [lokf_pkg::MAX_FLIPS];
   logic [lokf_pkg::POS_W-1:0] cell_pick [lokf_pkg::MAX_FLIPS];
   logic [lokf_pkg::POS_W-1:0] group_ff  [lokf_pkg::GROUPS];
   logic [lokf_pkg::POS_W-1:0] group_in  [lokf_pkg::GROUPS];

   for (genvar i = 0; i < lokf_pkg::MAX_FLIPS; i++) begin : g_cell
      logic [lokf_pkg::POS_W-1:0] left;
      if (i == 0) begin : g_head
         assign left = new_pos;
      end else begin : g_body
         assign left = cell_pos[i-1];
      end
      lokf_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .left_pos (left),
         .sel      (pick_en && (pick_index == lokf_pkg::IDX_W'(i))),
         .pos      (cell_pos[i]),
         .pick     (cell_pick[i])
      );
   end

   // first tree level: OR of each group of cells, registered
   always_comb begin
      for (int g = 0; g < lokf_pkg::GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < lokf_pkg::GROUP_SIZE; k++) begin
            if (g * lokf_pkg::GROUP_SIZE + k < lokf_pkg::MAX_FLIPS) begin
               group_in[g] = group_in[g] | cell_pick[g * lokf_pkg::GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         group_ff <= group_in;
      end
   end

   always_comb begin
      picked_pos = '0;
      for (int g = 0; g < lokf_pkg::GROUPS; g++) begin
         picked_pos = picked_pos | group_ff[g];
      end
   end

endmodule

### hw/rtl/lokf_span.sv
`timescale 1ns / 1ps
// Window start and best length tracking, plus the response payload register.
// Depends on lokf_pkg.
module lokf_span (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  lokf_pkg::lokf_meta_type     meta,
   input  logic [lokf_pkg::POS_W-1:0]  picked_pos,
   output logic [lokf_pkg::LEN_W-1:0]  best_length,
   output logic                        done_res,
   output logic                        overflow
);

   logic [lokf_pkg::LEN_W-1:0] window_start_ff, window_start_in;
   logic [lokf_pkg::LEN_W-1:0] best_ff, best_in;
   logic [lokf_pkg::LEN_W-1:0] best_out_ff;
   logic                       done_ff, overflow_ff;
   logic [lokf_pkg::LEN_W-1:0] start_new;
   logic [lokf_pkg::LEN_W-1:0] span_len;
   logic [lokf_pkg::LEN_W-1:0] best_new;

   always_comb begin
      priority if (meta.drop) begin
         start_new = lokf_pkg::LEN_W'(picked_pos) + 1'b1;
      end else if (meta.zero_restart) begin
         start_new = meta.here + 1'b1;
      end else begin
         start_new = window_start_ff;
      end
      span_len = meta.here + 1'b1 - start_new;
      best_new = (meta.counted && (span_len > best_ff)) ? span_len : best_ff;

      window_start_in = window_start_ff;
      best_in         = best_ff;
      if (step) begin
         if (meta.last) begin
            window_start_in = '0;
            best_in         = '0;
         end else if (meta.counted) begin
            window_start_in = start_new;
            best_in         = best_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_start_ff <= '0;
         best_ff         <= '0;
      end else begin
         window_start_ff <= window_start_in;
         best_ff         <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         best_out_ff <= best_new;
         done_ff     <= meta.last;
         overflow_ff <= meta.overflow;
      end
   end

   assign best_length = best_out_ff;
   assign done_res    = done_ff;
   assign overflow    = overflow_ff;

endmodule

### hw/rtl/longest_ones_with_k_flips.sv
`timescale 1ns / 1ps
// Longest run of ones allowing up to max_flips zeros, one bit per request.
// One request per cycle unless the receiver stalls; each passes the chain stage, then
// the span stage. The chain shifts once per counted zero while the limit is nonzero.
// Reset is synchronous, active high: clears counters, window and best length at once;
// the chain's positions are left as they are and are only read after being written.
module longest_ones_with_k_flips (
   input  logic                            clock,
   input  logic                            reset,
   lokf_req_if.sink                        req_bus,
   lokf_rsp_if.source                      rsp_bus,
   input  logic                            csr_write_enable,
   input  logic [lokf_pkg::CFG_W-1:0]      csr_write_data
);

   logic [lokf_pkg::CFG_W-1:0] max_flips_ff;
   logic [lokf_pkg::CNT_W-1:0] zero_count_ff, zero_count_in;
   logic [lokf_pkg::LEN_W-1:0] position_ff, position_in;
   logic                       overflow_flag_ff, overflow_flag_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic                       out_valid_ff, out_valid_in;
   lokf_pkg::lokf_meta_type    meta_ff, meta_in;

   logic                       out_take, s1_take, accept, step;
   logic [lokf_pkg::CNT_W-1:0] limit;
   logic [lokf_pkg::CNT_W-1:0] limit_less;
   logic                       counted, is_zero, insert, drop, zero_restart;
   logic [lokf_pkg::POS_W-1:0] picked_pos;

   assign out_take       = !out_valid_ff || rsp_bus.ready;
   assign s1_take        = !s1_valid_ff || out_take;
   assign req_bus.ready  = s1_take;
   assign accept         = req_bus.valid && s1_take;
   assign step           = s1_valid_ff && out_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_flips_ff <= '0;
      end else if (csr_write_enable) begin
         max_flips_ff <= csr_write_data;
      end
   end

   always_comb begin
      limit = (int'(max_flips_ff) > lokf_pkg::MAX_FLIPS) ?
              lokf_pkg::CNT_W'(lokf_pkg::MAX_FLIPS) : lokf_pkg::CNT_W'(max_flips_ff);
      limit_less   = limit - 1'b1;
      counted      = position_ff < lokf_pkg::LEN_W'(lokf_pkg::MAX_LEN);
      is_zero      = counted && !req_bus.bit_value;
      insert       = is_zero && (limit != '0);
      drop         = insert && (zero_count_ff >= limit);
      zero_restart = is_zero && (limit == '0);

      zero_count_in    = zero_count_ff;
      position_in      = position_ff;
      overflow_flag_in = overflow_flag_ff;
      if (accept) begin
         if (req_bus.last) begin
            zero_count_in    = '0;
            position_in      = '0;
            overflow_flag_in = 1'b0;
         end else begin
            // after dropping, limit-1 zeros remain and the new one joins them
            priority if (drop) begin
               zero_count_in = limit;
            end else if (insert) begin
               zero_count_in = zero_count_ff + 1'b1;
            end else if (zero_restart) begin
               zero_count_in = '0;
            end else begin
               zero_count_in = zero_count_ff;
            end
            if (counted) begin
               position_in = position_ff + 1'b1;
            end else begin
               overflow_flag_in = 1'b1;
            end
         end
      end

      meta_in.here         = position_ff;
      meta_in.drop         = drop;
      meta_in.zero_restart = zero_restart;
      meta_in.counted      = counted;
      meta_in.last         = req_bus.last;
      meta_in.overflow     = overflow_flag_ff || !counted;

      s1_valid_in  = s1_take ? accept : s1_valid_ff;
      out_valid_in = out_take ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_count_ff    <= '0;
         position_ff      <= '0;
         overflow_flag_ff <= 1'b0;
         s1_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         zero_count_ff    <= zero_count_in;
         position_ff      <= position_in;
         overflow_flag_ff <= overflow_flag_in;
         s1_valid_ff      <= s1_valid_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         meta_ff <= meta_in;
      end
   end

   // the limit-th most recent zero bounds the new window
   lokf_chain u_chain (
      .clock      (clock),
      .shift_en   (accept && insert),
      .new_pos    (position_ff[lokf_pkg::POS_W-1:0]),
      .pick_en    (accept && drop),
      .pick_index (limit_less[lokf_pkg::IDX_W-1:0]),
      .load_en    (s1_take),
      .picked_pos (picked_pos)
   );

   lokf_span u_span (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .meta        (meta_ff),
      .picked_pos  (picked_pos),
      .best_length (rsp_bus.best_length),
      .done_res    (rsp_bus.done_res),
      .overflow    (rsp_bus.overflow)
   );

   assign rsp_bus.valid = out_valid_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      int'(zero_count_ff) <= lokf_pkg::MAX_FLIPS)
      else $error("zero count above ring depth");

   a_position_sat : assert property (@(posedge clock) disable iff (reset)
      position_ff <= lokf_pkg::LEN_W'(lokf_pkg::MAX_LEN))
      else $error("position passed saturation");

   a_last_restart : assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.last |=> position_ff == '0 && zero_count_ff == '0
                                 && !overflow_flag_ff)
      else $error("state not restarted after last request");

   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_take |=> s1_valid_ff && $stable(meta_ff))
      else $error("stalled stage lost its request");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for longest_ones_with_k_flips: framed random bit streams, bursty sender, stalling
// receiver, every response checked against a behavioral sliding-window predictor.
// Depends on lokf_pkg, lokf_if (lokf_req_if, lokf_rsp_if) and the RTL top level.
module tb;

   typedef struct packed {
      logic [lokf_pkg::LEN_W-1:0] best_length;
      logic                       done_res;
      logic                       overflow;
   } window_result_type;

   typedef enum {ROW_SET_LIMIT, ROW_REQUEST} row_kind_type;
   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   typedef struct {
      row_kind_type kind;
      int           value;
      logic         bit_value;
      logic         last;
      logic         typed;
      int           typed_best;
   } directed_row_type;

   localparam int NUM_ROWS    = 27;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 200;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [lokf_pkg::CFG_W-1:0] csr_write_data;

   lokf_req_if req ();
   lokf_rsp_if rsp ();

   longest_ones_with_k_flips dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req),
      .rsp_bus          (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [lokf_pkg::CFG_W-1:0] flip_limit;
   logic [15:0]                zero_ring [lokf_pkg::MAX_FLIPS];
   logic [lokf_pkg::CNT_W-1:0] zeros_held;
   logic [lokf_pkg::IDX_W-1:0] oldest_zero;
   logic [lokf_pkg::IDX_W-1:0] newest_zero;
   logic [lokf_pkg::LEN_W-1:0] window_start;
   logic [lokf_pkg::LEN_W-1:0] seq_position;
   logic [lokf_pkg::LEN_W-1:0] best_window;
   logic                       seq_overflow;

   window_result_type pending_results [$];
   int mismatch_count = 0;
   int burst_left = 0;

   directed_row_type directed_rows [NUM_ROWS] = '{
      // zero limit straight out of reset
      '{ROW_REQUEST,   0, 1'b1, 1'b0, 1'b1, 1},
      '{ROW_REQUEST,   0, 1'b0, 1'b0, 1'b1, 1},
      '{ROW_REQUEST,   0, 1'b1, 1'b1, 1'b1, 1},
      '{ROW_REQUEST,   0, 1'b0, 1'b1, 1'b1, 0},
      '{ROW_SET_LIMIT, 1, 1'b0, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b1, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b0, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b1, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b0, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b1, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b1, 1'b1, 1'b0, 0},
      '{ROW_SET_LIMIT, 2, 1'b0, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b0, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b0, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b0, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b1, 1'b1, 1'b0, 0},
      '{ROW_SET_LIMIT, 3, 1'b0, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b0, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b0, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b0, 1'b0, 1'b0, 0},
      // lowered with three zeros held: next zero drops them all at once
      '{ROW_SET_LIMIT, 1, 1'b0, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b0, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b1, 1'b1, 1'b0, 0},
      // above MAX_FLIPS clamps
      '{ROW_SET_LIMIT, 127, 1'b0, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b0, 1'b1, 1'b1, 1},
      '{ROW_SET_LIMIT, 64, 1'b0, 1'b0, 1'b0, 0},
      '{ROW_REQUEST,   0, 1'b1, 1'b1, 1'b1, 1}
   };

   function automatic void restart_window();
      zeros_held   = '0;
      oldest_zero  = '0;
      newest_zero  = '0;
      window_start = '0;
      seq_position = '0;
      best_window  = '0;
      seq_overflow = 1'b0;
   endfunction

   function automatic logic [lokf_pkg::IDX_W-1:0] ring_advance(
         input logic [lokf_pkg::IDX_W-1:0] p);
      return (int'(p) == lokf_pkg::MAX_FLIPS - 1) ? '0 : p + 1'b1;
   endfunction

   function automatic window_result_type predict_window(input logic b, input logic l);
      window_result_type          r;
      int                         limit;
      int                         here;
      logic [lokf_pkg::LEN_W-1:0] span;
      limit = (int'(flip_limit) > lokf_pkg::MAX_FLIPS) ? lokf_pkg::MAX_FLIPS
                                                       : int'(flip_limit);
      if (int'(seq_position) >= lokf_pkg::MAX_LEN) begin
         seq_overflow = 1'b1;
      end else begin
         here = int'(seq_position);
         if (!b) begin
            while (zeros_held != 0 && int'(zeros_held) >= limit) begin
               window_start = lokf_pkg::LEN_W'(zero_ring[oldest_zero]) + 1'b1;
               oldest_zero  = ring_advance(oldest_zero);
               zeros_held   = zeros_held - 1'b1;
            end
            if (limit == 0) begin
               window_start = lokf_pkg::LEN_W'(here + 1);
            end else begin
               zero_ring[newest_zero] = here[15:0];
               newest_zero = ring_advance(newest_zero);
               zeros_held  = zeros_held + 1'b1;
            end
         end
         span = lokf_pkg::LEN_W'(here + 1) - window_start;
         if (span > best_window) best_window = span;
         seq_position = lokf_pkg::LEN_W'(here + 1);
      end
      r.best_length = best_window;
      r.done_res    = l;
      r.overflow    = seq_overflow;
      if (l) restart_window();
      return r;
   endfunction

   // sender: bursts of random length, random gaps; returns at a falling edge
   task automatic send_request(input logic b, input logic l, input logic typed,
                               input int typed_best);
      window_result_type predicted;
      if (burst_left == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 20);
      end
      req.valid     <= 1'b1;
      req.bit_value <= b;
      req.last      <= l;
      do @(posedge clock); while (!req.ready);
      predicted = predict_window(b, l);
      if (typed) predicted.best_length = lokf_pkg::LEN_W'(typed_best);
      pending_results.push_back(predicted);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic set_limit(input int value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= lokf_pkg::CFG_W'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      flip_limit = lokf_pkg::CFG_W'(value);
   endtask

   // receiver stall pattern
   initial begin
      stall_mode_type mode;
      int             mode_left;
      int             tick;
      rsp.ready = 1'b0;
      mode      = STALL_NONE;
      mode_left = 0;
      tick      = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 400);
         end
         mode_left--;
         tick++;
         case (mode)
            STALL_NONE:   rsp.ready <= 1'b1;
            STALL_LIGHT:  rsp.ready <= ($urandom_range(0, 3) != 0);
            STALL_HEAVY:  rsp.ready <= ($urandom_range(0, 3) == 0);
            default:      rsp.ready <= ((tick % 5) < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      window_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response: best_length %0d done_res %0b overflow %0b",
                   rsp.best_length, rsp.done_res, rsp.overflow);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp.best_length !== want.best_length) begin
               $error("best_length mismatch: expected %0d, got %0d",
                      want.best_length, rsp.best_length);
               mismatch_count++;
            end
            if (rsp.done_res !== want.done_res) begin
               $error("done_res mismatch: expected %0b, got %0b", want.done_res, rsp.done_res);
               mismatch_count++;
            end
            if (rsp.overflow !== want.overflow) begin
               $error("overflow mismatch: expected %0b, got %0b", want.overflow, rsp.overflow);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #40ms;
      $display("longest_ones_with_k_flips test failed");
      $finish;
   end

   initial begin
      int   row;
      int   phase;
      int   n;
      int   seq_left;
      int   zero_odds;
      int   limit_value;
      logic b;
      logic l;
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.bit_value    = 1'b0;
      req.last         = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      flip_limit       = '0;
      restart_window();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < NUM_ROWS; row++) begin
         if (directed_rows[row].kind == ROW_SET_LIMIT)
            set_limit(directed_rows[row].value);
         else
            send_request(directed_rows[row].bit_value, directed_rows[row].last,
                         directed_rows[row].typed, directed_rows[row].typed_best);
      end

      seq_left  = 0;
      zero_odds = 8;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: limit_value = 0;
            1: limit_value = 1;
            2: limit_value = 127;
            3: limit_value = 3;
            4: limit_value = 64;
            5: limit_value = $urandom_range(0, 127);
            6: limit_value = 2;
            default: limit_value = 65;
         endcase
         // sequences stay open across the write, so the limit changes mid-sequence
         set_limit(limit_value);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (seq_left == 0) begin
               seq_left = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 400)
                                                      : $urandom_range(1, 40);
               case ($urandom_range(0, 4))
                  0: zero_odds = 8;
                  1: zero_odds = 2;
                  2: zero_odds = 14;
                  3: zero_odds = 1;
                  default: zero_odds = $urandom_range(0, 16);
               endcase
            end
            b = ($urandom_range(0, 15) >= zero_odds);
            // occasional early last breaks a sequence short
            l = (seq_left == 1) || ($urandom_range(0, 63) == 0);
            if (l) seq_left = 0;
            else seq_left--;
            send_request(b, l, 1'b0, 0);
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("longest_ones_with_k_flips test passed");
      else
         $display("longest_ones_with_k_flips test failed");
      $finish;
   end

endmodule

### sim.f
hw/rtl/lokf_pkg.sv
hw/rtl/lokf_if.sv
hw/rtl/lokf_cell.sv
hw/rtl/lokf_chain.sv
hw/rtl/lokf_span.sv
hw/rtl/longest_ones_with_k_flips.sv
tb/tb.sv
